// File: hdl/vtr_pkg.sv
// Shared types and constants for the velocity/time recovery block.
// Used by vtr_front, vtr_queue, vtr_back and velocity_time_recovery_top.
`default_nettype none
package vtr_pkg;

  // Reset value of the speed sum floor register, Q8.8 m/s
  localparam logic [15:0] FLOOR_RESET = 16'd26;

  // Front-to-back queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Square root: one result bit per two bits of the 32-bit operand, one step per cycle
  localparam int SQRT_STEPS  = 16;
  // Divider: 42-bit dividend (ds << 9, padded), two quotient bits per cycle
  localparam int DIV_W       = 42;
  localparam int DIV_CYCLES  = DIV_W / 2;
  // Largest possible speed magnitude, floor(sqrt(2^31 - 1))
  localparam logic [15:0] MAG_MAX = 16'd46340;

  // Item classified by the front, carried out by the back
  typedef struct packed {
    logic [30:0]        sq_clamped;  // squared speed, negative clamped to zero
    logic signed [15:0] accel_dir;   // acceleration with direction applied
    logic               rev;         // reverse travel
    logic [31:0]        ds;          // arc step, zero if arc went backwards
    logic               first;       // starts a new profile
  } vtr_entry_t;

  // Result item
  typedef struct packed {
    logic [31:0]        elapsed_time;
    logic signed [15:0] accel_out;
    logic signed [16:0] signed_speed;
  } vtr_result_t;

endpackage
`default_nettype wire

// File: hdl/velocity_time_recovery_top.sv
// Each path point goes through the back end in order: it is picked up from
// the queue, the square root yields one result bit per cycle, the time-step
// divide loads the divisor and then forms two quotient bits per step, and the
// result is registered once the output register is free; a first point skips
// the divide. The front end takes a new point whenever its two-entry queue
// has room, so up to two points wait while one is worked on and a result
// waits in the output register. The floor register is written over the cfg
// channel, which is always ready.
// Top level of the velocity/time recovery block; instantiates vtr_front,
// vtr_queue and vtr_back, and holds the floor register. Uses vtr_pkg.
`default_nettype none
module velocity_time_recovery_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,      // speed_sum_floor
  // input points
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [87:0] s_tdata,       // squared_speed, accel_in, reverse_dir, arc_length, zero pad
  input  wire logic        s_tuser,       // first_point
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata        // signed_speed, accel_out, elapsed_time, zero pad
);
  import vtr_pkg::*;

  logic        [15:0] speed_sum_floor;
  logic               push;
  vtr_entry_t         push_data;
  logic               full;
  logic               pop;
  vtr_entry_t         pop_data;
  logic               not_empty;
  vtr_result_t        result;

  // Floor register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_sum_floor <= FLOOR_RESET;
    end else if (cfg_valid) begin
      speed_sum_floor <= cfg_data;
    end
  end

  vtr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .squared_speed (s_tdata[31:0]),
    .accel_in      (s_tdata[47:32]),
    .reverse_dir   (s_tdata[48]),
    .arc_length    (s_tdata[80:49]),
    .first_point   (s_tuser),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  vtr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  vtr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .speed_sum_floor (speed_sum_floor),
    .q_valid         (not_empty),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_data        (result)
  );

  // Result packing, signed_speed lowest, zero pad highest
  assign m_tdata = {7'd0, result.elapsed_time, result.accel_out, result.signed_speed};

endmodule
`default_nettype wire

// File: hdl/vtr_front.sv
// Front end: accepts path points, clamps the squared speed, applies the
// direction to the acceleration and forms the arc step. Uses vtr_pkg.
`default_nettype none
module vtr_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        squared_speed,
  input  wire logic [15:0]        accel_in,
  input  wire logic               reverse_dir,
  input  wire logic [31:0]        arc_length,
  input  wire logic               first_point,
  output logic                    push,
  output vtr_pkg::vtr_entry_t     push_data,
  input  wire logic               full
);
  import vtr_pkg::*;

  logic [31:0] prev_arc;
  logic        accept;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign push     = accept;

  // Classify the point
  always_comb begin
    push_data.sq_clamped = squared_speed[31] ? 31'd0 : squared_speed[30:0];
    push_data.rev        = reverse_dir;
    push_data.first      = first_point;
    if (!reverse_dir) begin
      push_data.accel_dir = accel_in;
    end else if (accel_in == 16'h8000) begin
      push_data.accel_dir = 16'sh7FFF;  // most negative value saturates
    end else begin
      push_data.accel_dir = -accel_in;
    end
    push_data.ds = (arc_length >= prev_arc) ? (arc_length - prev_arc) : 32'd0;
  end

  // Previous arc length follows the accepted points in order
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_arc <= '0;
    end else if (accept) begin
      prev_arc <= arc_length;
    end
  end

endmodule
`default_nettype wire

// File: hdl/vtr_queue.sv
// Short register queue between the front and the back end.
// Uses vtr_pkg for the entry type and depth.
`default_nettype none
module vtr_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire vtr_pkg::vtr_entry_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output vtr_pkg::vtr_entry_t     pop_data,
  output logic                    not_empty
);
  import vtr_pkg::*;

  vtr_entry_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

// File: hdl/vtr_back.sv
// Back end: iterative square root, two-bit-per-cycle divider for the time
// step, time accumulation and the output register. Uses vtr_pkg.
`default_nettype none
module vtr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [15:0]        speed_sum_floor,
  input  wire logic               q_valid,
  input  wire vtr_pkg::vtr_entry_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output vtr_pkg::vtr_result_t    out_data
);
  import vtr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  vtr_entry_t       item;
  logic [4:0]       step;
  // square root
  logic [31:0]      sq_rem;
  logic [31:0]      sq_root;
  logic [31:0]      sq_bit;
  logic [31:0]      sq_trial;
  // divider
  logic [16:0]      divisor;
  logic [16:0]      div_rem;
  logic [DIV_W-1:0] quo;
  logic [17:0]      sh1;
  logic [17:0]      sh2;
  logic [16:0]      rem1;
  logic [16:0]      rem2;
  logic             qb1;
  logic             qb2;
  // profile state
  logic [15:0]      prev_speed_mag;
  logic [31:0]      time_acc;
  logic [31:0]      time_next;
  logic [32:0]      time_sum;
  logic [16:0]      speed_sum;
  logic [16:0]      floor_eff;
  logic             load_out;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  // Divisor: summed speeds, bounded below by the floor (zero acts as one)
  assign speed_sum = {1'b0, prev_speed_mag} + {1'b0, sq_root[15:0]};
  assign floor_eff = (speed_sum_floor == 16'd0) ? 17'd1 : {1'b0, speed_sum_floor};

  // One square root step
  assign sq_trial = sq_root + sq_bit;

  // Two restoring division steps
  always_comb begin
    sh1  = {div_rem, quo[DIV_W-1]};
    qb1  = (sh1 >= {1'b0, divisor});
    rem1 = qb1 ? 17'(sh1 - {1'b0, divisor}) : sh1[16:0];
    sh2  = {rem1, quo[DIV_W-2]};
    qb2  = (sh2 >= {1'b0, divisor});
    rem2 = qb2 ? 17'(sh2 - {1'b0, divisor}) : sh2[16:0];
  end

  // Saturating time accumulation, cleared on a first point
  always_comb begin
    time_sum = {1'b0, time_acc} + {1'b0, quo[31:0]};
    if (item.first) begin
      time_next = 32'd0;
    end else if ((|quo[DIV_W-1:32]) || time_sum[32]) begin
      time_next = 32'hFFFF_FFFF;
    end else begin
      time_next = time_sum[31:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_SQRT;
      ST_SQRT: begin
        if (step == 5'(SQRT_STEPS - 1)) begin
          state_next = item.first ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV:  if (step == 5'(DIV_CYCLES)) state_next = ST_DONE;
      ST_DONE: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          item    <= q_data;
          sq_rem  <= {1'b0, q_data.sq_clamped};
          sq_root <= '0;
          sq_bit  <= 32'h4000_0000;
          step    <= '0;
        end
      end
      ST_SQRT: begin
        if (sq_rem >= sq_trial) begin
          sq_rem  <= sq_rem - sq_trial;
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (step == 5'(SQRT_STEPS - 1)) begin
          step <= '0;
        end else begin
          step <= step + 5'd1;
        end
      end
      ST_DIV: begin
        if (step == '0) begin
          divisor <= (speed_sum < floor_eff) ? floor_eff : speed_sum;
          div_rem <= '0;
          quo     <= {1'b0, item.ds, 9'd0};
          step    <= 5'd1;
        end else begin
          div_rem <= rem2;
          quo     <= {quo[DIV_W-3:0], qb1, qb2};
          step    <= step + 5'd1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Profile state, committed when the result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_speed_mag <= '0;
      time_acc       <= '0;
    end else if (load_out) begin
      prev_speed_mag <= sq_root[15:0];
      time_acc       <= time_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.signed_speed <= item.rev ? -$signed({1'b0, sq_root[15:0]})
                                        : $signed({1'b0, sq_root[15:0]});
      out_data.accel_out    <= item.accel_dir;
      out_data.elapsed_time <= time_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (sq_root[15:0] <= MAG_MAX) && (sq_root[31:16] == '0))
    else $error("square root out of range");
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && (step != '0) |-> (divisor != '0))
    else $error("zero divisor");
  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    load_out && !item.first |-> (time_next >= time_acc))
    else $error("elapsed time went backwards");
`endif

endmodule
`default_nettype wire

// File: dv/vtr_checker.sv
// Checker for velocity_time_recovery_top: watches the cfg, point and result channels,
// predicts speed, signed acceleration and elapsed time for every point, compares in order.
// Depends on vtr_pkg for the result layout and the reset value of the floor register.
module vtr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,   // speed_sum_floor
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,    // squared_speed, accel_in, reverse_dir, arc_length, zero pad
  input  logic        s_tuser,    // first_point
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,    // signed_speed, accel_out, elapsed_time, zero pad
  output int          err_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import vtr_pkg::*;

  localparam logic signed [15:0] ACC_MIN  = 16'sh8000;
  localparam logic signed [15:0] ACC_MAX  = 16'sh7FFF;
  localparam logic [31:0]        TIME_SAT = 32'hFFFF_FFFF;
  localparam int                 MAX_REPORTS = 10;

  // predictor state
  logic [15:0] speed_floor;
  logic [15:0] prev_mag;
  logic [31:0] prev_arc_pos;
  logic [31:0] time_sum;

  vtr_result_t expected_results[$];
  int fails = 0;
  int reported = 0;
  int result_no = 0;

  // largest r with r*r <= x, one result bit at a time from the top
  function automatic logic [15:0] floor_sqrt(input logic [31:0] x);
    logic [15:0] r;
    logic [15:0] trial;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = r | (16'd1 << i);
      if ({16'd0, trial} * {16'd0, trial} <= x) r = trial;
    end
    return r;
  endfunction

  // one path point: speed, direction-signed accel, and the running time
  function automatic vtr_result_t predict_speed_time(input logic [31:0] sq,
                                                     input logic signed [15:0] acc,
                                                     input logic rev,
                                                     input logic [31:0] arc,
                                                     input logic first_pt);
    vtr_result_t res;
    logic [15:0] mag;
    logic [63:0] ds, sum, floor_eff, t;
    mag = sq[31] ? 16'd0 : floor_sqrt(sq);
    res.signed_speed = rev ? (17'd0 - {1'b0, mag}) : {1'b0, mag};
    if (!rev) res.accel_out = acc;
    else if (acc == ACC_MIN) res.accel_out = ACC_MAX;
    else res.accel_out = -acc;

    if (first_pt) begin
      time_sum = '0;
    end else begin
      ds = (arc >= prev_arc_pos) ? {32'd0, arc - prev_arc_pos} : 64'd0;
      sum = 64'(prev_mag) + 64'(mag);
      floor_eff = (speed_floor == 16'd0) ? 64'd1 : 64'(speed_floor);
      if (sum < floor_eff) sum = floor_eff;
      t = 64'(time_sum) + ((ds << 9) / sum);
      time_sum = (t > 64'(TIME_SAT)) ? TIME_SAT : t[31:0];
    end
    prev_mag = mag;
    prev_arc_pos = arc;
    res.elapsed_time = time_sum;
    return res;
  endfunction

  // follow the three channels at each rising edge
  always @(posedge clk) begin
    vtr_result_t got, want;
    if (rst) begin
      speed_floor = FLOOR_RESET;
      prev_mag = '0;
      prev_arc_pos = '0;
      time_sum = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) speed_floor = cfg_data;

      if (m_tvalid && m_tready) begin
        got = m_tdata[64:0];
        if (expected_results.size() == 0) begin
          fails++;
          if (reported < MAX_REPORTS)
            $display("ERROR: result %0d arrived with nothing pending: speed %0d accel %0d time %0d",
                     result_no, got.signed_speed, got.accel_out, got.elapsed_time);
          reported++;
        end else begin
          want = expected_results.pop_front();
          if (got.signed_speed !== want.signed_speed || got.accel_out !== want.accel_out ||
              got.elapsed_time !== want.elapsed_time) begin
            fails++;
            if (reported < MAX_REPORTS)
              $display("ERROR: result %0d: expected speed %0d accel %0d time %0d, got %0d %0d %0d",
                       result_no, want.signed_speed, want.accel_out, want.elapsed_time,
                       got.signed_speed, got.accel_out, got.elapsed_time);
            reported++;
          end
        end
        result_no++;
      end

      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(),
                                predict_speed_time(s_tdata[31:0], s_tdata[47:32],
                                                   s_tdata[48], s_tdata[80:49], s_tuser));
    end
    err_count <= fails;
    pending <= expected_results.size();
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for velocity_time_recovery_top: clock, reset, point stimulus in profiles,
// floor register writes, result back-pressure and the verdict. Uses vtr_pkg and vtr_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vtr_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 280;
  localparam int DRAIN_TAIL  = 100;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;   // speed_sum_floor
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;    // squared_speed, accel_in, reverse_dir, arc_length, zero pad
  logic        s_tuser;    // first_point
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;    // signed_speed, accel_out, elapsed_time, zero pad

  int          err_count;
  int          pending;
  int          burst_left = 0;
  int          items_sent = 0;
  logic [31:0] cur_arc = '0;
  bit          hold_req = 1'b0;
  logic [15:0] phase_floor [6];

  velocity_time_recovery_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  vtr_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .err_count (err_count),
    .pending   (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // squared speed: negative, zero, largest, small, exact squares, anything
  function automatic logic [31:0] pick_sq();
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0: return $urandom() | 32'h8000_0000;
      1: return 32'd0;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 32'h0004_0000);
      4: begin
        r = $urandom_range(0, 46340);
        return r * r;
      end
      5: return $urandom();
      default: return $urandom() & 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [15:0] pick_acc();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // next arc position: mostly small steps forward, some stops, reversals, big jumps
  function automatic logic [31:0] next_arc(input logic [31:0] from);
    case ($urandom_range(0, 19))
      0: return from;
      1: return from - $urandom_range(1, 32'h0001_0000);
      2: return from + $urandom();
      default: return from + $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  // offer one item, with random gaps between bursts; returns at a falling edge
  task automatic send_point(input logic [31:0] sq, input logic [15:0] acc, input logic rev,
                            input logic [31:0] arc, input logic first_pt);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    s_tvalid = 1'b1;
    s_tdata = {7'd0, arc, rev, acc, sq};
    s_tuser = first_pt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
    cur_arc = arc;
  endtask

  task automatic send_random_point(input logic first_pt, input logic [31:0] arc);
    send_point(pick_sq(), pick_acc(), 1'($urandom_range(0, 1)), arc, first_pt);
  endtask

  // a profile: a first point, then points along the path
  task automatic run_profile(input int len);
    send_random_point(1'b1, ($urandom_range(0, 3) == 0) ? $urandom()
                                                        : $urandom_range(0, 32'h0010_0000));
    for (int k = 1; k < len; k++) send_random_point(1'b0, next_arc(cur_arc));
  endtask

  // stop offering until every pending result is out
  task automatic wait_drain();
    s_tvalid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_floor(input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly profiles, some stray points, some pauses until drained
  task automatic run_phase(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1: send_random_point(1'($urandom_range(0, 1)), $urandom());
        2: wait_drain();
        default: run_profile(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40));
      endcase
    end
  endtask

  // result side: ready patterns that change now and then, plus long hold-offs on request
  initial begin
    int mode, mode_left, tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          0: m_tready = 1'b1;
          1: m_tready = 1'($urandom_range(0, 1));
          2: m_tready = ($urandom_range(0, 5) == 0);
          default: m_tready = ((tick % 7) < 4);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    phase_floor[0] = 16'd1;
    phase_floor[1] = FLOOR_RESET;
    phase_floor[2] = 16'($urandom_range(2, 65534));
    phase_floor[3] = 16'hFFFF;
    phase_floor[4] = 16'd0;
    phase_floor[5] = 16'($urandom_range(2, 600));
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // no profile start yet: the reset state is the previous point
    send_point(32'h0001_0000, 16'h0100, 1'b0, 32'h0002_0000, 1'b0);
    // negative squared speeds; most negative accel reversed
    send_point(32'h8000_0000, 16'h8000, 1'b1, 32'h0003_0000, 1'b0);
    send_point(32'hFFFF_FFFF, 16'h7FFF, 1'b0, 32'h0004_0000, 1'b0);
    // largest squared speed on a new profile
    send_point(32'h7FFF_FFFF, 16'h7FFF, 1'b1, 32'h0004_8000, 1'b1);
    send_point(32'h0004_0000, 16'h8000, 1'b0, 32'h0005_0000, 1'b0);
    // arc going backwards, then standing still
    send_point(32'h0009_0000, 16'h0000, 1'b1, 32'h0001_0000, 1'b0);
    send_point(32'h0000_0000, 16'hFFFF, 1'b0, 32'h0001_0000, 1'b0);
    // whole arc range at zero speed: time saturates and stays there
    send_point(32'h0000_0000, 16'h0001, 1'b0, 32'h0000_0000, 1'b1);
    send_point(32'h0000_0000, 16'h0001, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h0000_0100, 16'h0080, 1'b0, 32'hFFFF_FFFF, 1'b0);
    // a first point clears the time
    send_point(32'h0000_0004, 16'h0001, 1'b0, 32'h0000_0000, 1'b1);
    send_point(32'h0001_0000, 16'hFF00, 1'b1, 32'h0000_8000, 1'b0);

    // floor written as zero acts as one
    wait_drain();
    write_floor(16'd0);
    send_point(32'h0000_0000, 16'h0000, 1'b0, 32'h0000_0000, 1'b1);
    send_point(32'h0000_0000, 16'h0000, 1'b0, 32'h0001_0000, 1'b0);
    send_point(32'h0000_0100, 16'h0000, 1'b1, 32'h0002_0000, 1'b0);

    // largest floor, above some speed sums but below the sum of two largest speeds
    wait_drain();
    write_floor(16'hFFFF);
    send_point(32'h7FFF_FFFF, 16'h1234, 1'b0, 32'h0000_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 16'hEDCC, 1'b1, 32'hFFFF_0000, 1'b0);
    send_point(32'h0100_0000, 16'h0001, 1'b0, 32'hFFFF_FFFF, 1'b0);

    // random phases, one floor setting each
    for (int p = 0; p < 6; p++) begin
      wait_drain();
      write_floor(phase_floor[p]);
      if (p == 0 || p == 3) begin
        // results held off while points keep coming, so the input backs up
        hold_req = 1'b1;
        run_profile(24);
      end
      run_phase(PHASE_ITEMS);
    end

    wait_drain();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
hdl/vtr_pkg.sv
hdl/vtr_front.sv
hdl/vtr_queue.sv
hdl/vtr_back.sv
hdl/velocity_time_recovery_top.sv
dv/vtr_checker.sv
dv/tb_top.sv
